@@ rtl/fmcp_pkg.sv @@
// ----------------------------------------------------------------------------
// fmcp_pkg
// Shared types and constants of the cross product FM discriminator.
// ----------------------------------------------------------------------------
package fmcp_pkg;

    localparam int RATIO_BITS    = 16;
    localparam int FRAC_BITS     = 15;
    localparam int GAIN_BITS     = 16;
    localparam int FREQ_BITS     = 17;
    localparam int PROD_BITS     = RATIO_BITS + GAIN_BITS + 1;
    localparam int OUT_DATA_BITS = ((FREQ_BITS + RATIO_BITS + 7) / 8) * 8;
    localparam int OUT_USER_BITS = 2;

    localparam logic [GAIN_BITS-1:0]  GAIN_RESET    = 16'd24000;
    localparam logic [RATIO_BITS-1:0] RATIO_POS_MAX = 16'h7FFF;
    localparam logic [RATIO_BITS-1:0] RATIO_NEG_MAX = 16'h8000;

    typedef struct packed {
        logic neg;
        logic zero;
        logic ovf;
    } t_flags;

endpackage

@@ rtl/fmcp_front.sv @@
// ----------------------------------------------------------------------------
// fmcp_front
// Sample history, cross product, squared magnitude, absolute value and
// range check ahead of the divider chain.
// ----------------------------------------------------------------------------
module fmcp_front
    import fmcp_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_i,
    input  logic signed [SAMPLE_BITS-1:0] i_q,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2*SAMPLE_BITS:0]        o_rem,
    output logic [2*SAMPLE_BITS-1:0]      o_div,
    output t_flags                        o_flags
);

    localparam int PW = 2 * SAMPLE_BITS;

    logic                          r_have_prev;
    logic signed [SAMPLE_BITS-1:0] r_prev_i;
    logic signed [SAMPLE_BITS-1:0] r_prev_q;

    logic                 r_v1;
    logic signed [PW-1:0] r_p_iq;
    logic signed [PW-1:0] r_p_qi;
    logic signed [PW-1:0] r_p_ii;
    logic signed [PW-1:0] r_p_qq;

    logic               r_v2;
    logic signed [PW:0] r_cross;
    logic [PW-1:0]      r_mag2;

    logic          r_v3;
    logic [PW-1:0] r_abs;
    logic [PW-1:0] r_mag3;
    logic          r_neg3;
    logic          r_zero3;

    logic          r_v4;
    logic [PW:0]   r_rem;
    logic [PW-1:0] r_div;
    t_flags        r_flags;

    logic ready1, ready2, ready3, ready4, accept;

    logic signed [PW-1:0] w_p_iq, w_p_qi, w_p_ii, w_p_qq;
    logic signed [PW:0]   w_cross;
    logic [PW-1:0]        w_mag;
    logic signed [PW:0]   w_abs;
    logic                 w_ovf;

    assign ready4  = !r_v4 || i_ready;
    assign ready3  = !r_v3 || ready4;
    assign ready2  = !r_v2 || ready3;
    assign ready1  = !r_v1 || ready2;
    assign o_ready = ready1;
    assign accept  = i_valid && ready1;

    assign w_p_iq  = PW'(r_prev_i) * PW'(i_q);
    assign w_p_qi  = PW'(r_prev_q) * PW'(i_i);
    assign w_p_ii  = PW'(r_prev_i) * PW'(r_prev_i);
    assign w_p_qq  = PW'(r_prev_q) * PW'(r_prev_q);
    assign w_cross = {r_p_iq[PW-1], r_p_iq} - {r_p_qi[PW-1], r_p_qi};
    assign w_mag   = r_p_ii + r_p_qq;
    assign w_abs   = r_cross[PW] ? -r_cross : r_cross;
    assign w_ovf   = {1'b0, r_abs} >= {r_mag3, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_prev_i    <= '0;
            r_prev_q    <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
        end else begin
            if (accept) begin
                r_have_prev <= 1'b1;
                r_prev_i    <= i_i;
                r_prev_q    <= i_q;
            end
            if (ready1) begin
                r_v1 <= accept && r_have_prev;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
            if (ready4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_iq <= w_p_iq;
            r_p_qi <= w_p_qi;
            r_p_ii <= w_p_ii;
            r_p_qq <= w_p_qq;
        end
        if (ready2 && r_v1) begin
            r_cross <= w_cross;
            r_mag2  <= w_mag;
        end
        if (ready3 && r_v2) begin
            r_abs   <= w_abs[PW-1:0];
            r_mag3  <= r_mag2;
            r_neg3  <= r_cross[PW];
            r_zero3 <= (r_mag2 == '0);
        end
        if (ready4 && r_v3) begin
            r_rem        <= {1'b0, r_abs};
            r_div        <= r_mag3;
            r_flags.neg  <= r_neg3;
            r_flags.zero <= r_zero3;
            r_flags.ovf  <= w_ovf;
        end
    end

    assign o_valid = r_v4;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_flags = r_flags;

endmodule

@@ rtl/fmcp_div_cell.sv @@
// ----------------------------------------------------------------------------
// fmcp_div_cell
// One restoring division step: settles one quotient bit and hands the
// shifted remainder to the next cell.
// ----------------------------------------------------------------------------
module fmcp_div_cell
    import fmcp_pkg::*;
#(
    parameter int WIDTH = 33
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [WIDTH-1:0]      i_rem,
    input  logic [WIDTH-2:0]      i_div,
    input  logic [RATIO_BITS-1:0] i_quo,
    input  t_flags                i_flags,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [WIDTH-1:0]      o_rem,
    output logic [WIDTH-2:0]      o_div,
    output logic [RATIO_BITS-1:0] o_quo,
    output t_flags                o_flags
);

    logic                  r_valid;
    logic [WIDTH-1:0]      r_rem;
    logic [WIDTH-2:0]      r_div;
    logic [RATIO_BITS-1:0] r_quo;
    t_flags                r_flags;

    logic             w_ge;
    logic [WIDTH-1:0] w_diff;
    logic [WIDTH-1:0] w_keep;

    assign o_ready = !r_valid || i_ready;
    assign w_ge    = i_rem >= {1'b0, i_div};
    assign w_diff  = i_rem - {1'b0, i_div};
    assign w_keep  = w_ge ? w_diff : i_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem   <= {w_keep[WIDTH-2:0], 1'b0};
            r_div   <= i_div;
            r_quo   <= {i_quo[RATIO_BITS-2:0], w_ge};
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_quo   = r_quo;
    assign o_flags = r_flags;

endmodule

@@ rtl/fmcp_back.sv @@
// ----------------------------------------------------------------------------
// fmcp_back
// Sign and saturation of the quotient, gain multiply, final shift and the
// output register.
// ----------------------------------------------------------------------------
module fmcp_back
    import fmcp_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [RATIO_BITS-1:0]        i_quo,
    input  t_flags                       i_flags,
    input  logic [GAIN_BITS-1:0]         i_gain,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [FREQ_BITS-1:0]  o_freq,
    output logic signed [RATIO_BITS-1:0] o_ratio,
    output logic                         o_zero,
    output logic                         o_sat
);

    logic                         r_v5;
    logic signed [RATIO_BITS-1:0] r_ratio5;
    logic                         r_sat5;
    logic                         r_zero5;

    logic                         r_v6;
    logic signed [PROD_BITS-1:0]  r_prod;
    logic signed [RATIO_BITS-1:0] r_ratio6;
    logic                         r_sat6;
    logic                         r_zero6;

    logic                         r_v7;
    logic signed [FREQ_BITS-1:0]  r_freq;
    logic signed [RATIO_BITS-1:0] r_ratio7;
    logic                         r_sat7;
    logic                         r_zero7;

    logic ready5, ready6, ready7;

    logic [RATIO_BITS:0]          w_quo_neg;
    logic signed [RATIO_BITS-1:0] w_ratio;
    logic                         w_sat;
    logic signed [PROD_BITS-1:0]  w_prod;
    logic signed [PROD_BITS-1:0]  w_shift;

    assign ready7  = !r_v7 || i_ready;
    assign ready6  = !r_v6 || ready7;
    assign ready5  = !r_v5 || ready6;
    assign o_ready = ready5;

    assign w_quo_neg = {(RATIO_BITS+1){1'b0}} - {1'b0, i_quo};

    always_comb begin
        w_ratio = '0;
        w_sat   = 1'b0;
        if (i_flags.zero) begin
            w_ratio = '0;
            w_sat   = 1'b0;
        end else if (i_flags.neg) begin
            if (i_flags.ovf || (i_quo > RATIO_NEG_MAX)) begin
                w_ratio = RATIO_NEG_MAX;
                w_sat   = 1'b1;
            end else begin
                w_ratio = w_quo_neg[RATIO_BITS-1:0];
            end
        end else begin
            if (i_flags.ovf || (i_quo > RATIO_POS_MAX)) begin
                w_ratio = RATIO_POS_MAX;
                w_sat   = 1'b1;
            end else begin
                w_ratio = i_quo;
            end
        end
    end

    assign w_prod  = PROD_BITS'(r_ratio5) * PROD_BITS'($signed({1'b0, i_gain}));
    assign w_shift = r_prod >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (ready5) begin
                r_v5 <= i_valid;
            end
            if (ready6) begin
                r_v6 <= r_v5;
            end
            if (ready7) begin
                r_v7 <= r_v6;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready5 && i_valid) begin
            r_ratio5 <= w_ratio;
            r_sat5   <= w_sat;
            r_zero5  <= i_flags.zero;
        end
        if (ready6 && r_v5) begin
            r_prod   <= w_prod;
            r_ratio6 <= r_ratio5;
            r_sat6   <= r_sat5;
            r_zero6  <= r_zero5;
        end
        if (ready7 && r_v6) begin
            r_freq   <= w_shift[FREQ_BITS-1:0];
            r_ratio7 <= r_ratio6;
            r_sat7   <= r_sat6;
            r_zero7  <= r_zero6;
        end
    end

    assign o_valid = r_v7;
    assign o_freq  = r_freq;
    assign o_ratio = r_ratio7;
    assign o_zero  = r_zero7;
    assign o_sat   = r_sat7;

`ifndef SYNTHESIS
    a_zero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero |-> o_ratio == '0 && !o_sat && o_freq == '0)
        else $error("zero magnitude result not cleared");
    a_sat_on_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sat |-> (o_ratio == RATIO_POS_MAX || o_ratio == RATIO_NEG_MAX))
        else $error("saturated ratio off its rail");
    a_freq_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_freq[FREQ_BITS-1] |-> o_ratio[RATIO_BITS-1])
        else $error("negative frequency from non-negative ratio");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule

@@ rtl/fm_cross_product_discriminator.sv @@
// ----------------------------------------------------------------------------
// fm_cross_product_discriminator
// FM discriminator: cross product of successive IQ samples over the previous
// squared magnitude, scaled by a programmable gain.
// ----------------------------------------------------------------------------
// Takes one IQ sample per transfer and returns one result per sample once a
// previous sample exists; the first sample after reset only loads history.
// The datapath is fully pipelined: one sample per cycle sustained while the
// output is ready. There are 23 register stages (4 front stages, a chain of
// 16 divider cells producing one quotient bit each, 3 back stages) between
// the input transfer and the output register. Write the gain only while the
// block is idle.
// ----------------------------------------------------------------------------
module fm_cross_product_discriminator
    import fmcp_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // i_sample, q_sample
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // freq_estimate, ratio
    output logic [OUT_DATA_BITS-1:0]               o_m_axis_tdata,
    // zero_magnitude, saturated
    output logic [OUT_USER_BITS-1:0]               o_m_axis_tuser,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [GAIN_BITS-1:0]                   i_cfg_data
);

    localparam int RW = 2 * SAMPLE_BITS + 1;

    logic [GAIN_BITS-1:0] r_gain;

    logic                  c_valid [0:RATIO_BITS];
    logic                  c_ready [0:RATIO_BITS];
    logic [RW-1:0]         c_rem   [0:RATIO_BITS];
    logic [RW-2:0]         c_div   [0:RATIO_BITS];
    logic [RATIO_BITS-1:0] c_quo   [0:RATIO_BITS];
    t_flags                c_flags [0:RATIO_BITS];

    logic signed [FREQ_BITS-1:0]  w_freq;
    logic signed [RATIO_BITS-1:0] w_ratio;
    logic                         w_zero;
    logic                         w_sat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_valid) begin
            r_gain <= i_cfg_data;
        end
    end

    fmcp_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_i     (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_q     (i_s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .o_valid (c_valid[0]),
        .i_ready (c_ready[0]),
        .o_rem   (c_rem[0]),
        .o_div   (c_div[0]),
        .o_flags (c_flags[0])
    );

    assign c_quo[0] = '0;

    for (genvar k = 0; k < RATIO_BITS; k++) begin : g_cell
        fmcp_div_cell #(
            .WIDTH (RW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_rem   (c_rem[k]),
            .i_div   (c_div[k]),
            .i_quo   (c_quo[k]),
            .i_flags (c_flags[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_div   (c_div[k+1]),
            .o_quo   (c_quo[k+1]),
            .o_flags (c_flags[k+1])
        );
    end

    fmcp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid[RATIO_BITS]),
        .o_ready (c_ready[RATIO_BITS]),
        .i_quo   (c_quo[RATIO_BITS]),
        .i_flags (c_flags[RATIO_BITS]),
        .i_gain  (r_gain),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_freq  (w_freq),
        .o_ratio (w_ratio),
        .o_zero  (w_zero),
        .o_sat   (w_sat)
    );

    assign o_m_axis_tdata = {{(OUT_DATA_BITS-FREQ_BITS-RATIO_BITS){1'b0}}, w_ratio, w_freq};
    assign o_m_axis_tuser = {w_sat, w_zero};

endmodule
